@@ rtl/utc_pkg.sv @@
package utc_pkg;

  // encoding modes held in the encoding_mode register
  typedef enum logic [1:0] {
    MODE_LATIN1     = 2'd0,
    MODE_UTF16_AUTO = 2'd1,
    MODE_UTF16LE    = 2'd2,
    MODE_UTF16BE    = 2'd3
  } mode_t;

  // result status codes
  typedef enum logic [2:0] {
    STAT_DATA       = 3'd0,
    STAT_END        = 3'd1,
    STAT_LONE_LOW   = 3'd2,
    STAT_NO_LOW     = 3'd3,
    STAT_TRUNC_BYTE = 3'd4,
    STAT_TRUNC_SURR = 3'd5
  } status_t;

  // input operation codes
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  // register index of encoding_mode
  localparam logic REG_ENCODING_MODE = 1'b0;

  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last_in_run;
  } out_item_t;

  // results caused by one input item
  typedef struct packed {
    logic [CNT_W-1:0]                 cnt;
    out_item_t [MAX_RESULTS-1:0]      item;
  } result_set_t;

endpackage

@@ rtl/utf16_latin1_to_utf8_transcoder_core.sv @@
// Byte-wide UTF-16 / Latin-1 to UTF-8 transcoder. Each transfer on the input
// channel carries one raw byte or an end-of-stream marker; each transfer on the
// output channel carries one UTF-8 byte or a status code, with last_in_run set
// on the final result of an input item. An item is decoded in the cycle it is
// accepted and its zero to four results are loaded into a four-entry result
// buffer that drains one result per cycle while out_stall is low. The
// single-byte output port sets the rate: a new item is accepted only when the
// buffer is empty or its last result is taken in that cycle. Writing
// encoding_mode (byte address 0) clears the decoder state; it must only be
// written while the block is idle.
module utf16_latin1_to_utf8_transcoder_core (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  utc_pkg::in_item_t   in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output utc_pkg::out_item_t  out_data,
  // configuration port
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import utc_pkg::*;

  // configuration and decoder state
  mode_t            mode_r;
  logic             first_pair_done_r, first_pair_done_nxt;
  logic             little_endian_r, little_endian_nxt;
  logic             held_byte_valid_r, held_byte_valid_nxt;
  logic [7:0]       held_byte_r, held_byte_nxt;
  logic             held_high_valid_r, held_high_valid_nxt;
  logic [9:0]       held_high_offset_r, held_high_offset_nxt;

  // result buffer
  out_item_t [MAX_RESULTS-1:0] buf_r, buf_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;

  logic        cfg_write;
  logic        in_take;
  logic        out_take;
  result_set_t res;

  // utf-8 encoding of one code point
  function automatic result_set_t encode_cp(input logic [20:0] cp);
    result_set_t r;
    r = '0;
    if (cp <= 21'h7f) begin
      r.cnt = CNT_W'(1);
      r.item[0].out_byte = cp[7:0];
    end else if (cp <= 21'h7ff) begin
      r.cnt = CNT_W'(2);
      r.item[0].out_byte = {3'b110, cp[10:6]};
      r.item[1].out_byte = {2'b10, cp[5:0]};
    end else if (cp <= 21'hffff) begin
      r.cnt = CNT_W'(3);
      r.item[0].out_byte = {4'b1110, cp[15:12]};
      r.item[1].out_byte = {2'b10, cp[11:6]};
      r.item[2].out_byte = {2'b10, cp[5:0]};
    end else begin
      r.cnt = CNT_W'(4);
      r.item[0].out_byte = {5'b11110, cp[20:18]};
      r.item[1].out_byte = {2'b10, cp[17:12]};
      r.item[2].out_byte = {2'b10, cp[11:6]};
      r.item[3].out_byte = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  function automatic result_set_t status_only(input status_t st);
    result_set_t r;
    r = '0;
    r.cnt = CNT_W'(1);
    r.item[0].status = st;
    return r;
  endfunction

  // handshakes
  assign cfg_write = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                     && (cfg_paddr[2] == REG_ENCODING_MODE);
  assign out_valid = (cnt_r != '0);
  assign out_take  = out_valid && !out_stall;
  assign in_stall  = (cnt_r > CNT_W'(1)) || ((cnt_r == CNT_W'(1)) && out_stall);
  assign in_take   = in_valid && !in_stall;
  assign out_data  = buf_r[0];

  // register read back
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_ENCODING_MODE) ? {30'd0, 2'(mode_r)} : 32'd0;

  // decode of one input item
  always_comb begin
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [15:0] unit;
    logic        is_high;
    logic        is_low;
    logic        is_bom;
    logic [20:0] cp;
    first_pair_done_nxt  = first_pair_done_r;
    little_endian_nxt    = little_endian_r;
    held_byte_valid_nxt  = held_byte_valid_r;
    held_byte_nxt        = held_byte_r;
    held_high_valid_nxt  = held_high_valid_r;
    held_high_offset_nxt = held_high_offset_r;
    res    = '0;
    b0     = held_byte_r;
    b1     = in_data.data_byte;
    unit   = little_endian_r ? {b1, b0} : {b0, b1};
    is_high = (unit[15:10] == 6'b110110);
    is_low  = (unit[15:10] == 6'b110111);
    is_bom  = 1'b0;
    cp      = 21'h10000 + {1'b0, held_high_offset_r, unit[9:0]};

    if (in_data.op == OP_EOS) begin
      // end of stream reports and returns to the start state
      if (mode_r != MODE_LATIN1 && held_byte_valid_r) begin
        res = status_only(STAT_TRUNC_BYTE);
      end else if (mode_r != MODE_LATIN1 && held_high_valid_r) begin
        res = status_only(STAT_TRUNC_SURR);
      end else begin
        res = status_only(STAT_END);
      end
      first_pair_done_nxt = 1'b0;
      little_endian_nxt   = (mode_r != MODE_UTF16BE);
      held_byte_valid_nxt = 1'b0;
      held_high_valid_nxt = 1'b0;
    end else if (mode_r == MODE_LATIN1) begin
      res = encode_cp({13'd0, in_data.data_byte});
    end else if (!held_byte_valid_r) begin
      // first byte of a unit
      held_byte_valid_nxt = 1'b1;
      held_byte_nxt       = in_data.data_byte;
    end else begin
      held_byte_valid_nxt = 1'b0;
      // byte-order mark on the first pair
      if (!first_pair_done_r) begin
        first_pair_done_nxt = 1'b1;
        if (b0 == 8'hff && b1 == 8'hfe) begin
          is_bom            = 1'b1;
          little_endian_nxt = 1'b1;
        end else if (b0 == 8'hfe && b1 == 8'hff) begin
          is_bom            = 1'b1;
          little_endian_nxt = 1'b0;
        end
      end
      if (!is_bom) begin
        if (held_high_valid_r) begin
          held_high_valid_nxt = 1'b0;
          if (is_low) begin
            res = encode_cp(cp);
          end else begin
            res = status_only(STAT_NO_LOW);
          end
        end else if (is_high) begin
          held_high_valid_nxt  = 1'b1;
          held_high_offset_nxt = unit[9:0];
        end else if (is_low) begin
          res = status_only(STAT_LONE_LOW);
        end else begin
          res = encode_cp({5'd0, unit});
        end
      end
    end

    // flag the final result of the item
    case (res.cnt)
      CNT_W'(1): res.item[0].last_in_run = 1'b1;
      CNT_W'(2): res.item[1].last_in_run = 1'b1;
      CNT_W'(3): res.item[2].last_in_run = 1'b1;
      CNT_W'(4): res.item[3].last_in_run = 1'b1;
      default:   ;
    endcase
  end

  // result buffer load and drain
  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (in_take) begin
      buf_nxt = res.item;
      cnt_nxt = res.cnt;
    end else if (out_take) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        buf_nxt[i] = buf_r[i + 1];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r            <= MODE_UTF16_AUTO;
      first_pair_done_r <= 1'b0;
      little_endian_r   <= 1'b1;
      held_byte_valid_r <= 1'b0;
      held_high_valid_r <= 1'b0;
      cnt_r             <= '0;
    end else if (cfg_write) begin
      mode_r            <= mode_t'(cfg_pwdata[1:0]);
      first_pair_done_r <= 1'b0;
      little_endian_r   <= (mode_t'(cfg_pwdata[1:0]) != MODE_UTF16BE);
      held_byte_valid_r <= 1'b0;
      held_high_valid_r <= 1'b0;
      cnt_r             <= cnt_nxt;
    end else begin
      if (in_take) begin
        first_pair_done_r <= first_pair_done_nxt;
        little_endian_r   <= little_endian_nxt;
        held_byte_valid_r <= held_byte_valid_nxt;
        held_high_valid_r <= held_high_valid_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (in_take) begin
      held_byte_r        <= held_byte_nxt;
      held_high_offset_r <= held_high_offset_nxt;
    end
  end

endmodule
